>>> src/mctp_tx_packetizer_assert.svh
// assertion macros for the mctp transmit packetizer
`ifndef MCTP_TX_PACKETIZER_ASSERT_SVH
`define MCTP_TX_PACKETIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCTP_TX_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MCTP_TX_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mctp_tx_pkg.sv
// shared types and constants of the mctp transmit packetizer
`timescale 1ns / 1ps
`default_nettype none
package mctp_tx_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] HDR_VERSION = 8'd1;
	localparam logic [1:0] SEQ_MASK    = 2'b11;
	localparam logic [2:0] TAG_MASK    = 3'b111;

	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;
	localparam logic [7:0] OWN_EID_RESET     = 8'd8;

	localparam logic [7:0] REG_MAX_PAYLOAD = 8'd0;
	localparam logic [7:0] REG_OWN_EID     = 8'd1;

	// one classified input byte, handed from front to back
	typedef struct packed {
		logic       hdr_en;
		logic [7:0] dest;
		logic [7:0] src;
		logic [7:0] flags;
		logic [7:0] data;
		logic       pkt_start;
		logic       pkt_end;
	} desc_t;

endpackage
`default_nettype wire

>>> src/mctp_tx_front.sv
// front end: message state tracking and per-byte classification
`timescale 1ns / 1ps
`default_nettype none
module mctp_tx_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           data_byte,
	input  wire  [15:0]          msg_length,
	input  wire  [7:0]           dest_eid,
	input  wire                  owner_flag,
	input  wire  [2:0]           resp_tag,
	input  wire                  bridge,
	input  wire  [7:0]           max_payload,
	input  wire  [7:0]           own_eid,
	output logic                 push,
	output mctp_tx_pkg::desc_t   push_desc,
	input  wire                  full
);
	import mctp_tx_pkg::*;

	logic [15:0] bytes_left_q;
	logic [7:0]  ipc_q;
	logic [1:0]  pidx_q;
	logic [2:0]  rtag_q;
	logic [7:0]  dest_q;
	logic        owner_q;
	logic [2:0]  tag_q;
	logic        bridge_q;
	logic        first_q;

	logic        new_msg;
	logic [15:0] bl;
	logic [7:0]  dest_c;
	logic        owner_c;
	logic [2:0]  tag_c;
	logic        br_c;
	logic        fp_c;
	logic [1:0]  pidx_c;
	logic [7:0]  ipc_c;
	logic [7:0]  limit;
	logic [2:0]  hdr_tag;
	logic        eom;
	logic        pend;
	logic        last_byte;

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		new_msg   = (bytes_left_q == 16'd0);
		bl        = new_msg ? ((msg_length == 16'd0) ? 16'd1 : msg_length) : bytes_left_q;
		dest_c    = new_msg ? dest_eid : dest_q;
		owner_c   = new_msg ? owner_flag : owner_q;
		tag_c     = new_msg ? (resp_tag & TAG_MASK) : tag_q;
		br_c      = new_msg ? bridge : bridge_q;
		fp_c      = new_msg ? 1'b1 : first_q;
		pidx_c    = new_msg ? 2'd0 : pidx_q;
		ipc_c     = new_msg ? 8'd0 : ipc_q;
		limit     = (max_payload == 8'd0) ? 8'd1 : max_payload;
		hdr_tag   = owner_c ? (rtag_q & TAG_MASK) : tag_c;
		eom       = (bl <= {8'd0, limit});
		last_byte = (bl == 16'd1);
		pend      = br_c ? last_byte
			: (last_byte || (({1'b0, ipc_c} + 9'd1) >= {1'b0, limit}));

		push_desc.hdr_en    = !br_c && (ipc_c == 8'd0);
		push_desc.dest      = dest_c;
		push_desc.src       = own_eid;
		push_desc.flags     = {fp_c, eom, pidx_c & SEQ_MASK, owner_c, hdr_tag};
		push_desc.data      = data_byte;
		push_desc.pkt_start = br_c && fp_c;
		push_desc.pkt_end   = pend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 16'd0;
			ipc_q        <= 8'd0;
			pidx_q       <= 2'd0;
			rtag_q       <= 3'd0;
			dest_q       <= 8'd0;
			owner_q      <= 1'b0;
			tag_q        <= 3'd0;
			bridge_q     <= 1'b0;
			first_q      <= 1'b1;
		end else if (push) begin
			bytes_left_q <= bl - 16'd1;
			first_q      <= 1'b0;
			dest_q       <= dest_c;
			owner_q      <= owner_c;
			tag_q        <= tag_c;
			bridge_q     <= br_c;
			// a bridged message keeps the count at zero, a closing byte always ends its packet
			if (br_c) begin
				ipc_q  <= ipc_c;
				pidx_q <= pidx_c;
			end else if (pend) begin
				ipc_q  <= 8'd0;
				pidx_q <= pidx_c + 2'd1;
			end else begin
				ipc_q  <= ipc_c + 8'd1;
				pidx_q <= pidx_c;
			end
			if (last_byte && !br_c && owner_c)
				rtag_q <= rtag_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

>>> src/mctp_tx_queue.sv
// small descriptor queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module mctp_tx_desc_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  mctp_tx_pkg::desc_t   push_desc,
	output logic                 full,
	input  wire                  pop,
	output mctp_tx_pkg::desc_t   head,
	output logic                 empty
);
	import mctp_tx_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> src/mctp_tx_back.sv
// back end: header insertion and output word register
`timescale 1ns / 1ps
`default_nettype none
module mctp_tx_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mctp_tx_pkg::desc_t   head,
	input  wire                  empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           out_byte,
	output logic                 pkt_start,
	output logic                 pkt_end,
	output logic                 last
);
	import mctp_tx_pkg::*;

	localparam int PH_W = $clog2(HEADER_BYTES + 1);

	logic [PH_W-1:0] phase_q;
	logic            load;
	logic            in_hdr;
	logic [7:0]      hdr_byte;

	assign load   = !empty && (!out_valid || out_ready);
	assign in_hdr = head.hdr_en && (phase_q < PH_W'(HEADER_BYTES));
	assign pop    = load && !in_hdr;

	always_comb begin
		unique case (phase_q)
			PH_W'(0): hdr_byte = HDR_VERSION;
			PH_W'(1): hdr_byte = head.dest;
			PH_W'(2): hdr_byte = head.src;
			PH_W'(3): hdr_byte = head.flags;
			default:  hdr_byte = head.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				phase_q   <= in_hdr ? phase_q + 1'b1 : '0;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (in_hdr) begin
				out_byte  <= hdr_byte;
				pkt_start <= (phase_q == '0);
				pkt_end   <= 1'b0;
				last      <= 1'b0;
			end else begin
				out_byte  <= head.data;
				pkt_start <= head.pkt_start;
				pkt_end   <= head.pkt_end;
				last      <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/mctp_tx_packetizer.sv
// top level of the mctp transmit packetizer
// Usage: message bytes enter on the s_ channel, one word per byte; the
// length, destination, tag owner, response tag and bridge flag are taken
// from the first byte of each message and ignored on the rest. Packet
// words leave on the m_ channel: tdata is the byte, tuser marks packet
// start and end, tlast marks the final word made from one input byte.
// The cfg channel writes max_payload (index 0) and own_eid (index 1); it
// is always ready and should only be used between messages.
// A non-bridged byte that opens a packet yields five words (four header, one
// payload), any other byte one word. The output register sends one word per
// cycle while m_tready is high, so plain payload bytes then stream at one per
// cycle and a packet opening costs four extra header words. The first output
// word is written to the queue when its input byte is accepted and then loaded
// into the output register.
// A two-entry queue decouples classification from header insertion, so
// input keeps flowing while output words wait for m_tready. When the
// receiver stalls, the output word holds and the queue fills; s_tready
// drops once it is full. Reset clears message state, the rolling tag, the
// queue and the output valid, and loads max_payload 64 and own_eid 8.
`timescale 1ns / 1ps
`default_nettype none
module mctp_tx_packetizer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// data_byte, msg_length, dest_eid, owner_flag, resp_tag, bridge, zero fill
	input  wire  [39:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// out_byte
	output logic [7:0]  m_tdata,
	// pkt_start, pkt_end
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [7:0]  cfg_data
);
	import mctp_tx_pkg::*;

	`include "mctp_tx_packetizer_assert.svh"

	logic [7:0] max_payload_q;
	logic [7:0] own_eid_q;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	desc_t      q_in;
	desc_t      q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
			own_eid_q     <= OWN_EID_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_PAYLOAD)
				max_payload_q <= cfg_data;
			else if (cfg_index == REG_OWN_EID)
				own_eid_q <= cfg_data;
		end
	end

	mctp_tx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.data_byte   (s_tdata[7:0]),
		.msg_length  (s_tdata[23:8]),
		.dest_eid    (s_tdata[31:24]),
		.owner_flag  (s_tdata[32]),
		.resp_tag    (s_tdata[35:33]),
		.bridge      (s_tdata[36]),
		.max_payload (max_payload_q),
		.own_eid     (own_eid_q),
		.push        (q_push),
		.push_desc   (q_in),
		.full        (q_full)
	);

	mctp_tx_desc_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	mctp_tx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.pkt_start (m_tuser[0]),
		.pkt_end   (m_tuser[1]),
		.last      (m_tlast)
	);

	// header words never close a packet
	`MCTP_TX_IMPLY(a_hdr_no_end, m_tvalid && !m_tlast, !m_tuser[1], "header word ends packet")
	// the front never writes a full queue
	`MCTP_TX_IMPLY(a_no_overflow, q_push, !q_full, "push into full queue")
	// the back never pops an empty queue
	`MCTP_TX_IMPLY(a_no_underflow, q_pop, !q_empty, "pop from empty queue")
	// a push without a pop leaves the queue occupied
	`MCTP_TX_NEXT(a_push_holds, q_push && !q_pop, !q_empty, "pushed word lost")

endmodule
`default_nettype wire

>>> tb/sv/tb_mctp_tx_packetizer.sv
// self-checking testbench of the mctp transmit packetizer: streams messages, predicts packet words
`timescale 1ns / 1ps
module tb_mctp_tx_packetizer;
	import mctp_tx_pkg::*;

	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] octet;
		logic       start;
		logic       stop;
		logic       fin;
	} pkt_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	mctp_tx_packetizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [39:0] pending_bytes[$];
	pkt_word_t   expected_words[$];
	int          bytes_queued = 0;
	int          bytes_accepted = 0;
	int          mismatches = 0;
	int          sender_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          quiet_cycles = 0;

	// packetizer image
	logic [7:0]  max_payload = MAX_PAYLOAD_RESET;
	logic [7:0]  own_eid = OWN_EID_RESET;
	logic [15:0] msg_remaining = '0;
	int          pkt_fill = 0;
	logic [1:0]  seq_num = '0;
	logic [2:0]  req_tag = '0;
	logic [7:0]  cur_dest = '0;
	logic        cur_owner = 1'b0;
	logic [2:0]  cur_tag = '0;
	logic        cur_bridge = 1'b0;
	logic        first_pkt = 1'b1;

	initial forever #5 clk = ~clk;

	function automatic void push_word(logic [7:0] b, logic s, logic e, logic f);
		expected_words.push_back({b, s, e, f});
	endfunction

	function automatic void packetize(logic [39:0] w);
		int         lim;
		logic [2:0] tag_v;
		logic       eom;
		logic       stop;
		if (msg_remaining == 0) begin
			msg_remaining = (w[23:8] == 16'd0) ? 16'd1 : w[23:8];
			cur_dest      = w[31:24];
			cur_owner     = w[32];
			cur_tag       = w[35:33];
			cur_bridge    = w[36];
			first_pkt     = 1'b1;
			seq_num       = '0;
			pkt_fill      = 0;
		end
		lim = (max_payload == 8'd0) ? 1 : int'(max_payload);
		if (cur_bridge) begin
			push_word(w[7:0], first_pkt, msg_remaining == 16'd1, 1'b1);
			first_pkt = 1'b0;
		end else begin
			if (pkt_fill == 0) begin
				tag_v = cur_owner ? req_tag : cur_tag;
				eom   = int'(msg_remaining) <= lim;
				push_word(HDR_VERSION, 1'b1, 1'b0, 1'b0);
				push_word(cur_dest, 1'b0, 1'b0, 1'b0);
				push_word(own_eid, 1'b0, 1'b0, 1'b0);
				push_word({first_pkt, eom, seq_num, cur_owner, tag_v}, 1'b0, 1'b0, 1'b0);
				first_pkt = 1'b0;
			end
			stop = (msg_remaining == 16'd1) || (pkt_fill + 1 >= lim);
			push_word(w[7:0], 1'b0, stop, 1'b1);
			if (stop) begin
				pkt_fill = 0;
				seq_num  = seq_num + 2'd1;
			end else begin
				pkt_fill = pkt_fill + 1;
			end
		end
		msg_remaining = msg_remaining - 16'd1;
		if (msg_remaining == 0) begin
			pkt_fill = 0;
			if (!cur_bridge && cur_owner)
				req_tag = req_tag + 3'd1;
		end
	endfunction

	task automatic queue_message(input int len_field, input logic [7:0] dest, input logic owner,
			input logic [2:0] tag, input logic bridge_flag);
		int          n;
		logic [39:0] w;
		n = (len_field == 0) ? 1 : len_field;
		for (int i = 0; i < n; i++) begin
			w[31:0]  = $urandom();
			w[39:32] = 8'($urandom_range(255, 0));
			w[39:37] = '0;
			if (i == 0) begin
				w[23:8]  = 16'(len_field);
				w[31:24] = dest;
				w[32]    = owner;
				w[35:33] = tag;
				w[36]    = bridge_flag;
			end
			pending_bytes.push_back(w);
			bytes_queued++;
		end
	endtask

	task automatic random_messages(input int target, input int long_len);
		int sent;
		int len;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(9, 0) == 0) ? $urandom_range(long_len, 13) : $urandom_range(12, 1);
			queue_message(len, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
				3'($urandom_range(7, 0)), $urandom_range(5, 0) == 0);
			sent += len;
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (bytes_accepted != bytes_queued || expected_words.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_MAX_PAYLOAD: max_payload = val;
			REG_OWN_EID:     own_eid = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [7:0] mp, input logic [7:0] eid);
		wait_idle();
		write_reg(REG_MAX_PAYLOAD, mp);
		write_reg(REG_OWN_EID, eid);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				packetize(s_tdata);
				bytes_accepted++;
				offer = 1'b0;
			end
			if (!offer && pending_bytes.size() > 0 &&
					$urandom_range(99, 0) >= sender_idle_pct) begin
				s_tdata <= pending_bytes.pop_front();
				offer = 1'b1;
			end
			s_tvalid <= offer;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_proc
		pkt_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: out_byte %0h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (m_tdata !== want.octet) begin
						$error("out_byte expected %0h got %0h", want.octet, m_tdata);
						mismatches++;
					end
					if (m_tuser[0] !== want.start) begin
						$error("pkt_start expected %0b got %0b", want.start, m_tuser[0]);
						mismatches++;
					end
					if (m_tuser[1] !== want.stop) begin
						$error("pkt_end expected %0b got %0b", want.stop, m_tuser[1]);
						mismatches++;
					end
					if (m_tlast !== want.fin) begin
						$error("last expected %0b got %0b", want.fin, m_tlast);
						mismatches++;
					end
				end
			end
			m_tready <= $urandom_range(99, 0) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL mctp_tx_packetizer");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, starting from reset register values
		queue_message(0, 8'hFF, 1'b1, 3'd0, 1'b0);
		queue_message(3, 8'h11, 1'b1, 3'd2, 1'b1);
		queue_message(2, 8'h00, 1'b0, 3'd7, 1'b0);
		queue_message(1, 8'h22, 1'b1, 3'd0, 1'b0);
		set_regs(8'd1, 8'hFF);
		queue_message(5, 8'h33, 1'b1, 3'd0, 1'b0);
		wait_idle();
		write_reg(REG_MAX_PAYLOAD, 8'd0);
		queue_message(2, 8'h44, 1'b0, 3'd5, 1'b0);
		set_regs(8'd2, 8'h00);
		queue_message(5, 8'h55, 1'b1, 3'd1, 1'b0);
		queue_message(1, 8'h66, 1'b0, 3'd0, 1'b1);

		// widest payload limit
		set_regs(8'd255, 8'hA5);
		queue_message(24, 8'h5A, 1'b0, 3'd3, 1'b0);

		set_regs(8'd7, 8'($urandom_range(255, 0)));
		random_messages(45, 30);

		set_regs(8'd3, 8'($urandom_range(255, 0)));
		sender_idle_pct = 75;
		random_messages(45, 30);

		set_regs(8'd1, 8'($urandom_range(255, 0)));
		sender_idle_pct = 0;
		recv_stall_pct  = 75;
		random_messages(25, 20);
		set_regs(8'd16, 8'($urandom_range(255, 0)));
		random_messages(25, 40);

		set_regs(8'($urandom_range(8, 2)), 8'($urandom_range(255, 0)));
		sender_idle_pct = 28;
		recv_stall_pct  = 28;
		random_messages(55, 30);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("PASS mctp_tx_packetizer");
		else
			$display("FAIL mctp_tx_packetizer");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/mctp_tx_pkg.sv
src/mctp_tx_front.sv
src/mctp_tx_queue.sv
src/mctp_tx_back.sv
src/mctp_tx_packetizer.sv
tb/sv/tb_mctp_tx_packetizer.sv
